### hw/rtl/b2e5_pkg.sv
`default_nettype none
package b2e5_pkg;

  localparam logic [2:0] RmNe = 3'd0;
  localparam logic [2:0] RmTz = 3'd1;
  localparam logic [2:0] RmDn = 3'd2;
  localparam logic [2:0] RmUp = 3'd3;
  localparam logic [2:0] RmNa = 3'd4;

  localparam logic [7:0] ExpSpecial = 8'hFF;
  localparam logic [7:0] ExpDenTop  = 8'h6E;
  localparam logic [7:0] ExpDenMid  = 8'h6F;
  localparam logic [7:0] ExpDenLow  = 8'h70;
  localparam logic [7:0] ExpMaxFin  = 8'h8E;
  localparam logic [7:0] ExpBias    = 8'h70;
  localparam logic [7:0] Fp8QNaN    = 8'h7E;
  localparam logic [4:0] ExpMaxOut  = 5'h1E;
  localparam logic [4:0] ExpInf     = 5'h1F;

  // Unpacked value between the classify and round stages.
  typedef struct packed {
    logic       sign;
    logic [4:0] rexp;
    logic [1:0] rman;
    logic       guard;
    logic       sticky;
    logic       sat;
    logic       special;
    logic [7:0] spec_val;
    logic       spec_inv;
  } unp_t;

endpackage
`default_nettype wire

### hw/rtl/b2e5_round.sv
`default_nettype none
module b2e5_round (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               valid_i,
  input  wire b2e5_pkg::unp_t unp_i,
  input  wire  [2:0]        mode_i,
  output logic              valid_o,
  output logic [7:0]        fp8_o,
  output logic              inexact_o,
  output logic              underflow_o,
  output logic              overflow_o,
  output logic              invalid_o
);
  import b2e5_pkg::*;

  logic       incr;
  logic [7:0] res;
  logic       valid_q;
  logic [7:0] fp8_q;
  logic [3:0] flags_q;
  logic [3:0] flags_d;

  always_comb begin
    unique case (mode_i)
      RmNe:    incr = unp_i.sat | (unp_i.guard & (unp_i.sticky | unp_i.rman[0]));
      RmDn:    incr = unp_i.sign & (unp_i.guard | unp_i.sticky);
      RmUp:    incr = ~unp_i.sign & (unp_i.guard | unp_i.sticky);
      RmNa:    incr = unp_i.guard;
      default: incr = 1'b0;
    endcase
    res = {unp_i.sign, unp_i.rexp, unp_i.rman} + {7'd0, incr};
    if (unp_i.special) begin
      flags_d = {3'b000, unp_i.spec_inv};
    end else begin
      flags_d[3] = unp_i.sat | unp_i.guard | unp_i.sticky;
      flags_d[2] = (unp_i.rexp == 5'd0) & (unp_i.guard | unp_i.sticky);
      flags_d[1] = unp_i.sat | (res[6:2] == ExpInf);
      flags_d[0] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    fp8_q   <= unp_i.special ? unp_i.spec_val : res;
    flags_q <= flags_d;
  end

  assign valid_o     = valid_q;
  assign fp8_o       = fp8_q;
  assign inexact_o   = flags_q[3];
  assign underflow_o = flags_q[2];
  assign overflow_o  = flags_q[1];
  assign invalid_o   = flags_q[0];

  a_sat_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && unp_i.sat && !unp_i.special |=> overflow_o && inexact_o)
    else $error("saturated input lost overflow");
  a_spec_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && unp_i.special |=> !inexact_o && !underflow_o && !overflow_o)
    else $error("special value raised flags");
  a_uf_inexact: assert property (@(posedge clk_i) disable iff (!rst_ni)
    underflow_o |-> inexact_o)
    else $error("underflow without inexact");
endmodule
`default_nettype wire

### hw/rtl/bf16_to_fp8_e5m2_convert.sv
`default_nettype none
// bfloat16 to FP8 E5M2 converter.
// Input: pulse start with bf16_value_i; busy is always low, so a new
// beat is taken every cycle.
// Output: done marks a one-cycle beat carrying fp8_value_o and the four
// exception flags. The receiver cannot stall; results come in input order.
// Pipeline: three register stages: input capture, classify/rebias and
// round/flag. Throughput: one beat per clock.
// rounding_mode is written through cfg_we_i/cfg_data_i; the user must do so
// only while idle, the block does not enforce it. Reset selects nearest-even
// and clears all valid bits; no beats are in flight afterwards. Payload registers are not reset.
module bf16_to_fp8_e5m2_convert (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         start,
  output logic        busy,
  input  wire  [15:0] bf16_value_i,
  output logic        done,
  output logic [7:0]  fp8_value_o,
  output logic        flag_inexact_o,
  output logic        flag_underflow_o,
  output logic        flag_overflow_o,
  output logic        flag_invalid_o,
  input  wire         cfg_we_i,
  input  wire  [2:0]  cfg_data_i
);
  import b2e5_pkg::*;

  logic [2:0]  mode_q;
  logic        v0_q, v1_q;
  logic [15:0] in_q;
  unp_t        unp_d, unp_q;
  logic        sign;
  logic [7:0]  ex;
  logic [6:0]  fr;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= RmNe;
      v0_q   <= 1'b0;
      v1_q   <= 1'b0;
    end else begin
      if (cfg_we_i) mode_q <= cfg_data_i;
      v0_q <= start;
      v1_q <= v0_q;
    end
  end

  // Classify by exponent range: special, zero/tiny, denormal positions, normal, saturate.
  always_comb begin
    sign  = in_q[15];
    ex    = in_q[14:7];
    fr    = in_q[6:0];
    unp_d = '0;
    unp_d.sign     = sign;
    unp_d.spec_val = {sign, ExpInf, 2'b00};
    if (ex == ExpSpecial) begin
      unp_d.special = 1'b1;
      if (fr != 7'd0) begin
        unp_d.spec_val = Fp8QNaN;
        unp_d.spec_inv = ~fr[6];
      end
    end else if (ex == 8'd0) begin
      unp_d.sticky = (fr != 7'd0);
    end else if (ex < ExpDenTop) begin
      unp_d.sticky = 1'b1;
    end else if (ex == ExpDenTop) begin
      unp_d.guard  = 1'b1;
      unp_d.sticky = (fr != 7'd0);
    end else if (ex == ExpDenMid) begin
      unp_d.rman   = 2'd1;
      unp_d.guard  = fr[6];
      unp_d.sticky = (fr[5:0] != 6'd0);
    end else if (ex == ExpDenLow) begin
      unp_d.rman   = {1'b1, fr[6]};
      unp_d.guard  = fr[5];
      unp_d.sticky = (fr[4:0] != 5'd0);
    end else if (ex <= ExpMaxFin) begin
      unp_d.rexp   = 5'(ex - ExpBias);
      unp_d.rman   = fr[6:5];
      unp_d.guard  = fr[4];
      unp_d.sticky = (fr[3:0] != 4'd0);
    end else begin
      unp_d.rexp   = ExpMaxOut;
      unp_d.rman   = 2'd3;
      unp_d.guard  = 1'b1;
      unp_d.sticky = 1'b1;
      unp_d.sat    = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q  <= bf16_value_i;
    unp_q <= unp_d;
  end

  b2e5_round u_round (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (v1_q),
    .unp_i       (unp_q),
    .mode_i      (mode_q),
    .valid_o     (done),
    .fp8_o       (fp8_value_o),
    .inexact_o   (flag_inexact_o),
    .underflow_o (flag_underflow_o),
    .overflow_o  (flag_overflow_o),
    .invalid_o   (flag_invalid_o)
  );

  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> ##2 done)
    else $error("result beat missing");
  a_nodone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v1_q |=> !done)
    else $error("spurious result beat");
  a_inv_nan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done && flag_invalid_o |-> fp8_value_o == Fp8QNaN)
    else $error("invalid without NaN");
endmodule
`default_nettype wire

### test/bf16_to_fp8_e5m2_convert_tb.sv
module bf16_to_fp8_e5m2_convert_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import b2e5_pkg::*;

  // One converted beat: the E5M2 byte plus its four exception flags.
  typedef struct packed {
    logic [7:0] fp8;
    logic       inexact;
    logic       underflow;
    logic       overflow;
    logic       invalid;
  } fp8_beat_t;

  // Scoreboard: converts each accepted bf16 beat and checks results in order.
  class e5m2_scoreboard;
    fp8_beat_t   pending_q[$];
    logic [2:0]  rnd_mode;
    int unsigned n_errors;

    function new();
      rnd_mode = RmNe;
      n_errors = 0;
    endfunction

    function automatic fp8_beat_t convert(logic [15:0] a);
      fp8_beat_t  r;
      logic       sgn, grd, stk, sat, inc;
      logic [7:0] ex;
      logic [6:0] fr;
      logic [4:0] rexp;
      logic [1:0] rman;
      logic [7:0] res;
      sgn = a[15];
      ex = a[14:7];
      fr = a[6:0];
      rexp = '0;
      rman = '0;
      grd = 1'b0;
      stk = 1'b0;
      sat = 1'b0;
      r = '0;
      if (ex == ExpSpecial) begin
        if (fr != 0) begin
          r.fp8 = Fp8QNaN;
          r.invalid = ~fr[6];
        end else begin
          r.fp8 = {sgn, ExpInf, 2'b00};
        end
        return r;
      end
      if (ex == 8'h00) begin
        stk = (fr != 0);
      end else if (ex < ExpDenTop) begin
        stk = 1'b1;
      end else if (ex == ExpDenTop) begin
        grd = 1'b1;
        stk = (fr != 0);
      end else if (ex == ExpDenMid) begin
        rman = 2'd1;
        grd = fr[6];
        stk = (fr[5:0] != 0);
      end else if (ex == ExpDenLow) begin
        rman = {1'b1, fr[6]};
        grd = fr[5];
        stk = (fr[4:0] != 0);
      end else if (ex <= ExpMaxFin) begin
        rexp = 5'(ex - ExpBias);
        rman = fr[6:5];
        grd = fr[4];
        stk = (fr[3:0] != 0);
      end else begin
        // beyond finite range: clamp to max finite, then round
        rexp = ExpMaxOut;
        rman = 2'd3;
        grd = 1'b1;
        stk = 1'b1;
        sat = 1'b1;
      end
      case (rnd_mode)
        RmNe: inc = sat | (grd & (stk | rman[0]));
        RmDn: inc = sgn & (grd | stk);
        RmUp: inc = ~sgn & (grd | stk);
        RmNa: inc = grd;
        default: inc = 1'b0;  // unused modes truncate
      endcase
      res = {sgn, rexp, rman} + 8'(inc);
      r.fp8 = res;
      r.inexact = sat | grd | stk;
      r.underflow = (rexp == 0) & (grd | stk);
      r.overflow = sat | (res[6:2] == ExpInf);
      return r;
    endfunction

    function void note_input(logic [15:0] a);
      pending_q.push_back(convert(a));
    endfunction

    function void check_result(fp8_beat_t got);
      fp8_beat_t exp_b;
      if (pending_q.size() == 0) begin
        $error("unexpected result beat fp8=%h", got.fp8);
        n_errors++;
        return;
      end
      exp_b = pending_q.pop_front();
      if (got.fp8 !== exp_b.fp8) begin
        $error("fp8_value: expected %h, got %h", exp_b.fp8, got.fp8);
        n_errors++;
      end
      if (got.inexact !== exp_b.inexact) begin
        $error("flag_inexact: expected %b, got %b", exp_b.inexact, got.inexact);
        n_errors++;
      end
      if (got.underflow !== exp_b.underflow) begin
        $error("flag_underflow: expected %b, got %b", exp_b.underflow, got.underflow);
        n_errors++;
      end
      if (got.overflow !== exp_b.overflow) begin
        $error("flag_overflow: expected %b, got %b", exp_b.overflow, got.overflow);
        n_errors++;
      end
      if (got.invalid !== exp_b.invalid) begin
        $error("flag_invalid: expected %b, got %b", exp_b.invalid, got.invalid);
        n_errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic [15:0] bf16_value_i = '0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_data_i = '0;
  logic        busy;
  logic        done;
  logic [7:0]  fp8_value_o;
  logic        flag_inexact_o, flag_underflow_o, flag_overflow_o, flag_invalid_o;

  e5m2_scoreboard sb = new();
  bit          quiet_tail = 1'b0;  // no sender gaps in the last stretch

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  bf16_to_fp8_e5m2_convert u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .bf16_value_i    (bf16_value_i),
    .done            (done),
    .fp8_value_o     (fp8_value_o),
    .flag_inexact_o  (flag_inexact_o),
    .flag_underflow_o(flag_underflow_o),
    .flag_overflow_o (flag_overflow_o),
    .flag_invalid_o  (flag_invalid_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_data_i      (cfg_data_i)
  );

  // Result monitor: sample at the edge that ends the done beat.
  always @(posedge clk_i) begin
    if (rst_ni && done === 1'b1) begin
      sb.check_result({fp8_value_o, flag_inexact_o, flag_underflow_o,
                       flag_overflow_o, flag_invalid_o});
    end
  end

  // Drive one bf16 beat; start stays high across back-to-back beats.
  task automatic send_value(logic [15:0] val);
    int gap;
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    bf16_value_i <= val;
    do @(posedge clk_i); while (busy !== 1'b0);
    sb.note_input(val);
  endtask

  // Drain in-flight beats, then write the rounding mode while idle.
  task automatic set_mode(logic [2:0] mode);
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_data_i <= mode;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.rnd_mode = mode;
  endtask

  // Random bf16 word weighted toward the interesting exponent bands.
  function automatic logic [15:0] pick_value();
    logic [7:0] ex;
    case ($urandom_range(0, 9))
      0: ex = 8'h00;
      1: ex = 8'hFF;
      2: ex = 8'(ExpDenTop + $urandom_range(0, 2));
      3: ex = 8'($urandom_range(8'h8D, 8'hFE));
      4: ex = 8'($urandom_range(1, 8'h6D));
      default: ex = 8'($urandom_range(8'h6C, 8'h90));
    endcase
    return {1'($urandom), ex, 7'($urandom)};
  endfunction

  initial begin
    logic [15:0] directed[$];
    logic [2:0]  modes[$];
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: zeros, denormals, band edges, ties, saturation, inf, NaNs.
    directed = '{16'h0000, 16'h8000, 16'h0001, 16'h807F, 16'h3700,
                 16'h3740, 16'h37C0, 16'h37E0, 16'h3830, 16'h3810,
                 16'h3818, 16'h4760, 16'h4768, 16'h4770, 16'hC77F,
                 16'h4780, 16'hFF7F, 16'h7F80, 16'hFF80, 16'h7FC0,
                 16'h7F81, 16'hFFFF, 16'h3F80, 16'hBF90};
    modes = '{RmNe, RmTz, RmDn, RmUp, RmNa, 3'd7};
    foreach (modes[m]) begin
      set_mode(modes[m]);
      foreach (directed[i]) send_value(directed[i]);
    end

    // Random part over several settings, unused codes included.
    for (int ph = 0; ph < 6; ph++) begin
      set_mode(ph < 5 ? 3'(ph) : 3'($urandom_range(5, 7)));
      if (ph == 5) quiet_tail = 1'b1;
      repeat (50) send_value(pick_value());
    end
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
    if (sb.n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
